/* hdl/pbnc_pkg.sv */
// Shared types, constants and helpers for the palette blend nearest-color block.
// Used by every module in hdl/; depends on nothing.
package pbnc_pkg;

    // Number of palette entries, one scan cell per entry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    localparam int INDEX_W = 8;   // width of palette index fields
    localparam int COMP_W  = 6;   // width of one color component
    localparam int SQ_W    = 12;  // square of a component difference
    localparam int DIST_W  = 14;  // sum of three squares

    // The starting best distance. Any real distance is at most 11907, so the
    // all-ones code always loses to the first entry, just like a huge sentinel.
    localparam logic [DIST_W-1:0] BEST_INIT = '1;
    localparam logic [DIST_W-1:0] MAX_DIST  = 14'd11907;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        color_t             color;
    } load_t;

    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  best_dist;
        logic [INDEX_W-1:0] best_idx;
    } token_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_WAIT,
        ST_LAUNCH,
        ST_SCAN,
        ST_PUSH
    } state_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        logic [SQ_W-1:0]   dw;
        d  = (a >= b) ? (a - b) : (b - a);
        dw = SQ_W'(d);
        return dw * dw;
    endfunction

    function automatic logic in_range(input logic [INDEX_W-1:0] idx);
        return ({1'b0, idx} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    endfunction

endpackage

/* hdl/pbnc_cell.sv */
// One scan cell: holds one palette entry, its distance to the current average,
// and the running best item handed on to the next cell. Depends on pbnc_pkg.
module pbnc_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pbnc_pkg::load_t             load,
    input  logic [pbnc_pkg::INDEX_W-1:0] cell_index,
    input  pbnc_pkg::color_t            avg_color,
    input  pbnc_pkg::token_t            tok_in,
    output pbnc_pkg::token_t            tok_out
);
    import pbnc_pkg::*;

    color_t            entry_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    token_t            tok_reg;
    token_t            tok_next;

    always_comb begin
        dist_next = DIST_W'(sq_diff(entry_reg.red,   avg_color.red))
                  + DIST_W'(sq_diff(entry_reg.green, avg_color.green))
                  + DIST_W'(sq_diff(entry_reg.blue,  avg_color.blue));
    end

    // Strictly less: an earlier cell keeps the win on a tie.
    always_comb begin
        tok_next = tok_in;
        if (dist_reg < tok_in.best_dist) begin
            tok_next.best_dist = dist_reg;
            tok_next.best_idx  = cell_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.en && (load.index == cell_index)) begin
            entry_reg <= load.color;
        end
        dist_reg           <= dist_next;
        tok_reg.best_dist  <= tok_next.best_dist;
        tok_reg.best_idx   <= tok_next.best_idx;
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hdl/pbnc_chain.sv */
// Row of scan cells, one per palette entry; the best-so-far item moves one
// cell per cycle. Depends on pbnc_pkg and pbnc_cell.
module pbnc_chain (
    input  logic             aclk,
    input  logic             aresetn,
    input  pbnc_pkg::load_t  load,
    input  pbnc_pkg::color_t avg_color,
    input  pbnc_pkg::token_t tok_in,
    output pbnc_pkg::token_t tok_out
);
    import pbnc_pkg::*;

    token_t tok [PALETTE_ENTRIES+1];

    assign tok[0] = tok_in;

    for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
        pbnc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (load),
            .cell_index (INDEX_W'(i)),
            .avg_color  (avg_color),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    assign tok_out = tok[PALETTE_ENTRIES];

endmodule

/* hdl/pbnc_fetch.sv */
// Operand fetch: a palette copy read at the two query indexes, and the
// component-wise average of the pair. Depends on pbnc_pkg.
module pbnc_fetch (
    input  logic                         aclk,
    input  pbnc_pkg::load_t              load,
    input  logic                         rd_en,
    input  logic [pbnc_pkg::INDEX_W-1:0] first_color,
    input  logic [pbnc_pkg::INDEX_W-1:0] second_color,
    input  logic                         avg_en,
    output pbnc_pkg::color_t             avg_color
);
    import pbnc_pkg::*;

    color_t mem [PALETTE_ENTRIES];

    color_t rd_a_reg;
    color_t rd_b_reg;
    logic   blk_a_reg;
    logic   blk_b_reg;
    color_t opa;
    color_t opb;
    color_t avg_reg;
    color_t avg_next;

    always_ff @(posedge aclk) begin
        if (load.en && in_range(load.index)) begin
            mem[load.index[IDX_W-1:0]] <= load.color;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg  <= mem[first_color[IDX_W-1:0]];
            rd_b_reg  <= mem[second_color[IDX_W-1:0]];
            blk_a_reg <= !in_range(first_color);
            blk_b_reg <= !in_range(second_color);
        end
    end

    // Out-of-range operands read as black.
    always_comb begin
        logic [COMP_W:0] sr;
        logic [COMP_W:0] sg;
        logic [COMP_W:0] sb;
        opa = blk_a_reg ? color_t'('0) : rd_a_reg;
        opb = blk_b_reg ? color_t'('0) : rd_b_reg;
        sr  = {1'b0, opa.red}   + {1'b0, opb.red};
        sg  = {1'b0, opa.green} + {1'b0, opb.green};
        sb  = {1'b0, opa.blue}  + {1'b0, opb.blue};
        avg_next.red   = sr[COMP_W:1];
        avg_next.green = sg[COMP_W:1];
        avg_next.blue  = sb[COMP_W:1];
    end

    always_ff @(posedge aclk) begin
        if (avg_en) begin
            avg_reg <= avg_next;
        end
    end

    assign avg_color = avg_reg;

endmodule

/* hdl/palette_blend_nearest_color_top.sv */
// Top level of the palette blend nearest-color block: handshakes, sequencer,
// operand fetch and the scan chain. Depends on pbnc_pkg, pbnc_fetch, pbnc_chain.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   s_      | in        | s_valid / s_ready  | command, entry_index, r/g/b, first/second
//   m_      | out       | m_valid / m_ready  | blend_index, best_distance
//
// A load item leaves the block ready again at once.
// A query item is fetched and averaged, then passes a settle state for the cell
// distances and the launch state, then the best-so-far item walks the row of
// cells one cell per cycle.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted. A stalled result only holds the block when a
// second query finishes before the first result is taken.
// Reset (aresetn low, synchronous) clears the sequencer and valid bits only;
// the palette is undefined until loaded.
module palette_blend_nearest_color_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [pbnc_pkg::INDEX_W-1:0] s_entry_index,
    input  logic [pbnc_pkg::COMP_W-1:0]  s_red_value,
    input  logic [pbnc_pkg::COMP_W-1:0]  s_green_value,
    input  logic [pbnc_pkg::COMP_W-1:0]  s_blue_value,
    input  logic [pbnc_pkg::INDEX_W-1:0] s_first_color,
    input  logic [pbnc_pkg::INDEX_W-1:0] s_second_color,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pbnc_pkg::INDEX_W-1:0] m_blend_index,
    output logic [pbnc_pkg::DIST_W-1:0]  m_best_distance
);
    import pbnc_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic   s_accept;
    load_t  load;
    logic   rd_en;
    logic   avg_en;
    color_t avg_color;
    token_t chain_in;
    token_t chain_out;
    logic   out_free;
    logic   push;

    logic [INDEX_W-1:0] res_idx_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [INDEX_W-1:0] m_idx_reg;
    logic [DIST_W-1:0]  m_dist_reg;

    // Take items only between queries.
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Broadcast a load to the fetch copy and to every cell in the same cycle.
    assign load.en          = s_accept && (s_command == CMD_LOAD);
    assign load.index       = s_entry_index;
    assign load.color.red   = s_red_value;
    assign load.color.green = s_green_value;
    assign load.color.blue  = s_blue_value;

    assign out_free = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_command == CMD_QUERY)) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:    state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_SCAN;
            ST_SCAN: begin
                if (chain_out.valid) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        rd_en              = s_accept && (s_command == CMD_QUERY);
        avg_en             = 1'b0;
        chain_in.valid     = 1'b0;
        chain_in.best_dist = BEST_INIT;
        chain_in.best_idx  = '0;
        push               = 1'b0;
        case (state_reg)
            ST_AVG:    avg_en         = 1'b1;
            ST_LAUNCH: chain_in.valid = 1'b1;
            ST_PUSH:   push           = out_free;
            default:   ;
        endcase
    end

    // Hold the result valid until taken; load a new one when pushed.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the chain tail; advance it to the output register on push.
    always_ff @(posedge aclk) begin
        if (chain_out.valid) begin
            res_idx_reg  <= chain_out.best_idx;
            res_dist_reg <= chain_out.best_dist;
        end
        if (push) begin
            m_idx_reg  <= res_idx_reg;
            m_dist_reg <= res_dist_reg;
        end
    end

    pbnc_fetch u_fetch (
        .aclk         (aclk),
        .load         (load),
        .rd_en        (rd_en),
        .first_color  (s_first_color),
        .second_color (s_second_color),
        .avg_en       (avg_en),
        .avg_color    (avg_color)
    );

    pbnc_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .avg_color (avg_color),
        .tok_in    (chain_in),
        .tok_out   (chain_out)
    );

    assign m_valid         = m_valid_reg;
    assign m_blend_index   = m_idx_reg;
    assign m_best_distance = m_dist_reg;

endmodule

/* hdl/pbnc_checker.sv */
// Port-level checker for the palette blend nearest-color top level, bound in
// below. Depends on pbnc_pkg.
module pbnc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_command,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [pbnc_pkg::INDEX_W-1:0] m_blend_index,
    input logic [pbnc_pkg::DIST_W-1:0]  m_best_distance
);
    import pbnc_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_blend_index)
                                && $stable(m_best_distance))
        else $error("result changed while stalled");

    // A query keeps the block busy in the next cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_QUERY) |=> !s_ready)
        else $error("ready after query accept");

    // A load never blocks the input.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_LOAD) |=> s_ready)
        else $error("not ready after load accept");

    // A new result only appears out of a query in work.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result without query in work");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_best_distance <= MAX_DIST))
        else $error("distance out of range");

endmodule

bind palette_blend_nearest_color_top pbnc_checker u_checker (.*);

/* tb/sv/pbnc_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the palette blend nearest-color testbench: palette mirror,
// blend predictor and result check. Depends on pbnc_pkg.
package pbnc_tb_pkg;

    import pbnc_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
    } blend_result_t;

    class palette_scoreboard;

        color_t        palette [PALETTE_ENTRIES];
        blend_result_t pending_blends [$];
        int unsigned   mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Update the palette mirror on a load, queue the predicted blend on a query.
        function void note_item(input logic cmd, input logic [INDEX_W-1:0] entry,
                                input color_t color, input logic [INDEX_W-1:0] first,
                                input logic [INDEX_W-1:0] second);
            if (cmd == CMD_LOAD) begin
                if (entry < PALETTE_ENTRIES)
                    palette[entry] = color;
            end else begin
                pending_blends.push_back(nearest_blend(first, second));
            end
        endfunction

        function int comp_sq(input int a, input int b);
            return (a - b) * (a - b);
        endfunction

        function blend_result_t nearest_blend(input logic [INDEX_W-1:0] first,
                                              input logic [INDEX_W-1:0] second);
            color_t        a;
            color_t        b;
            int            mean_r;
            int            mean_g;
            int            mean_b;
            int            cand_dist;
            int            best;
            int            i;
            blend_result_t res;
            a = (first < PALETTE_ENTRIES) ? palette[first] : '0;
            b = (second < PALETTE_ENTRIES) ? palette[second] : '0;
            mean_r = (int'(a.red) + int'(b.red)) >> 1;
            mean_g = (int'(a.green) + int'(b.green)) >> 1;
            mean_b = (int'(a.blue) + int'(b.blue)) >> 1;
            best = 32'h0fff_ffff;
            res.index = '0;
            for (i = 0; i < PALETTE_ENTRIES; i++) begin
                cand_dist = comp_sq(int'(palette[i].red), mean_r)
                          + comp_sq(int'(palette[i].green), mean_g)
                          + comp_sq(int'(palette[i].blue), mean_b);
                // strict less-than keeps the lowest index on ties
                if (cand_dist < best) begin
                    best = cand_dist;
                    res.index = i[INDEX_W-1:0];
                end
            end
            res.distance = best[DIST_W-1:0];
            return res;
        endfunction

        function void check_blend(input logic [INDEX_W-1:0] index,
                                  input logic [DIST_W-1:0] distance);
            blend_result_t want;
            if (pending_blends.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: index %0d distance %0d", index, distance);
                return;
            end
            want = pending_blends.pop_front();
            if (index !== want.index || distance !== want.distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: index %0d (expected %0d) distance %0d (expected %0d)",
                             index, want.index, distance, want.distance);
            end
        endfunction

    endclass

endpackage

/* tb/sv/palette_blend_nearest_color_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for palette_blend_nearest_color_top: drives load and query
// items, mirrors the palette and checks every blend result. Depends on pbnc_pkg, pbnc_tb_pkg.
module palette_blend_nearest_color_top_test;

    import pbnc_pkg::*;
    import pbnc_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1680;
    // a query scans the whole palette; leave room for one more
    localparam int DRAIN_CYCLES = 300;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_command       = CMD_LOAD;
    logic [INDEX_W-1:0]   s_entry_index   = '0;
    logic [COMP_W-1:0]    s_red_value     = '0;
    logic [COMP_W-1:0]    s_green_value   = '0;
    logic [COMP_W-1:0]    s_blue_value    = '0;
    logic [INDEX_W-1:0]   s_first_color   = '0;
    logic [INDEX_W-1:0]   s_second_color  = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [INDEX_W-1:0]   m_blend_index;
    logic [DIST_W-1:0]    m_best_distance;

    palette_scoreboard    book;
    int unsigned          burst_left;
    int unsigned          ready_hold;

    palette_blend_nearest_color_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_entry_index   (s_entry_index),
        .s_red_value     (s_red_value),
        .s_green_value   (s_green_value),
        .s_blue_value    (s_blue_value),
        .s_first_color   (s_first_color),
        .s_second_color  (s_second_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blend_index   (m_blend_index),
        .m_best_distance (m_best_distance)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver stall pattern: alternate long free-running stretches, choppy
    // random toggling and long stalls. A long stall lets a second query
    // finish behind an untaken result, which backs the block up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    m_ready    <= 1'b1;
                    ready_hold <= $urandom_range(1, 400);
                end
                4, 5, 6, 7: begin
                    m_ready    <= 1'($urandom_range(0, 1));
                    ready_hold <= $urandom_range(0, 3);
                end
                default: begin
                    m_ready    <= 1'b0;
                    ready_hold <= $urandom_range(1, 600);
                end
            endcase
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    // Check every result the moment its handshake completes; values read here
    // are the ones the block presented before this edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_blend(m_blend_index, m_best_distance);
    end

    // Present one item, hold it until accepted, note it, then pace the sender:
    // items go back to back inside a burst, and a random gap follows each burst.
    task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] entry,
                             input color_t color, input logic [INDEX_W-1:0] first,
                             input logic [INDEX_W-1:0] second);
        int unsigned gap;
        int unsigned pick;
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_entry_index  <= entry;
        s_red_value    <= color.red;
        s_green_value  <= color.green;
        s_blue_value   <= color.blue;
        s_first_color  <= first;
        s_second_color <= second;
        do @(posedge aclk); while (!s_ready);
        book.note_item(cmd, entry, color, first, second);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                gap = $urandom_range(1, 3);
            else if (pick < 95)
                gap = $urandom_range(4, 60);
            else
                gap = $urandom_range(100, 400);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(0, 19);
        end
    endtask

    // Mostly free colors, some from a coarse grid (many ties), some at the corners.
    function automatic color_t random_color();
        color_t      c;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            c.red   = COMP_W'($urandom_range(0, 63));
            c.green = COMP_W'($urandom_range(0, 63));
            c.blue  = COMP_W'($urandom_range(0, 63));
        end else if (pick < 8) begin
            c.red   = 6'(21 * $urandom_range(0, 3));
            c.green = 6'(21 * $urandom_range(0, 3));
            c.blue  = 6'(21 * $urandom_range(0, 3));
        end else begin
            c.red   = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            c.green = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            c.blue  = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end
        return c;
    endfunction

    // Load one entry; fill the ignored color pair with noise.
    task automatic load_entry(input logic [INDEX_W-1:0] entry, input logic [COMP_W-1:0] r,
                              input logic [COMP_W-1:0] g, input logic [COMP_W-1:0] b);
        color_t c;
        c.red   = r;
        c.green = g;
        c.blue  = b;
        send_item(CMD_LOAD, entry, c, INDEX_W'($urandom_range(0, 255)),
                  INDEX_W'($urandom_range(0, 255)));
    endtask

    // Query a blend; fill the ignored entry and color fields with noise.
    task automatic query_blend(input logic [INDEX_W-1:0] first,
                               input logic [INDEX_W-1:0] second);
        send_item(CMD_QUERY, INDEX_W'($urandom_range(0, 255)), random_color(), first, second);
    endtask

    function automatic logic [INDEX_W-1:0] random_index();
        // favor the low corner so the same entries get rewritten and re-queried
        if ($urandom_range(0, 3) == 0)
            return INDEX_W'($urandom_range(0, 15));
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    initial begin
        int          i;
        int          n;
        book       = new();
        burst_left = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the whole palette first: every query scans all entries, and an
        // unwritten entry must never be read.
        for (i = 0; i < PALETTE_ENTRIES; i++)
            load_entry(i[INDEX_W-1:0], 6'd5, 6'd5, 6'd5);

        // Directed: all entries equal, so the lowest index wins the tie
        query_blend(8'd0, 8'd255);
        // black and white at the two ends of the palette
        load_entry(8'd0, 6'd0, 6'd0, 6'd0);
        load_entry(8'd255, 6'd63, 6'd63, 6'd63);
        query_blend(8'd0, 8'd255);
        query_blend(8'd255, 8'd255);
        query_blend(8'd0, 8'd0);
        // exact match in the middle of the palette
        load_entry(8'd128, 6'd31, 6'd31, 6'd31);
        query_blend(8'd255, 8'd0);
        // opposite colors that average to the same mid gray
        load_entry(8'd7, 6'd63, 6'd0, 6'd63);
        load_entry(8'd8, 6'd0, 6'd63, 6'd0);
        query_blend(8'd7, 8'd8);
        // odd sums truncate downward
        load_entry(8'd9, 6'd1, 6'd1, 6'd1);
        query_blend(8'd0, 8'd9);
        // equal exact matches at two indexes: the lower one wins
        load_entry(8'd200, 6'd31, 6'd31, 6'd31);
        query_blend(8'd0, 8'd255);
        load_entry(8'd128, 6'd63, 6'd0, 6'd0);
        query_blend(8'd0, 8'd255);
        query_blend(8'd7, 8'd255);
        query_blend(8'd128, 8'd8);

        // Random mix: loads keep reshaping the palette, queries probe it
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 4)
                query_blend(random_index(), random_index());
            else
                send_item(CMD_LOAD, random_index(), random_color(),
                          INDEX_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, 255)));
        end
        s_valid <= 1'b0;

        // Drain: wait out the outstanding blends, then watch for strays
        while (book.pending_blends.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (book.mismatches == 0 && book.pending_blends.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
